// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check cons in the same cycle as ante
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/trc_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer rate calibrator package
// Word types, register indexes, codes and shared helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package trc_pkg;

    localparam int TIMER_WIDTH = 32;
    localparam int MAX_ROUNDS  = 15;
    localparam int RATE_W      = 32;
    localparam int TICK_W      = 32;
    localparam int SUM_W       = 36;
    localparam int CNT_W       = 4;
    localparam int WIN_W       = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESET_RATE  = 2'd2;

    localparam logic [1:0] SRC_MEASURED = 2'd0;
    localparam logic [1:0] SRC_PRESET   = 2'd1;
    localparam logic [1:0] SRC_FAILED   = 2'd2;

    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [RATE_W-1:0] timer_count;
        logic [TICK_W-1:0] ref_tick;
    } in_word_t;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [1:0]        source;
        logic [CNT_W-1:0]  good_rounds;
    } out_word_t;

    typedef struct packed {
        logic [WIN_W-1:0]  window_ticks;
        logic [CNT_W-1:0]  round_limit;
        logic [RATE_W-1:0] preset_rate;
    } cfg_t;

    typedef enum logic {
        OP_EVAL,
        OP_PRESET
    } job_op_t;

    typedef struct packed {
        job_op_t op;
        logic    first;
        logic    last;
        logic    edges_ok;
    } job_ctl_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRST,
        PH_START_EDGE,
        PH_END_EDGE
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_HI,
        BK_LO,
        BK_MEAN
    } bk_state_t;

    function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] r;
        r = (w == '0) ? WIN_W'(1) : w;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/timer_rate_calibrator.sv =====
// ----------------------------------------------------------------------------
// Timer rate calibrator
// Measures free-running timer counts per reference tick over several rounds.
// ----------------------------------------------------------------------------
// Start and sample words are taken one per cycle while the four-entry job
// queue has room. A start with a nonzero preset rate queues a job that the
// back unit, once free, turns into the preset result word through the queue
// and the result register. Each round end queues one job that the back unit
// runs on a shared one-bit-per-cycle divider of DW = max(TIMER_WIDTH, 36) bits:
// the two rate divisions by the window hold the back unit each round,
// overlapped with sampling of later rounds. On the last round the mean takes
// a third division before the result is valid, if any round was good; else a
// failed result word is given without it. A waiting result holds the back
// unit; once the queue fills, input stalls. No clearing pass follows reset.
// Configuration must be written only while idle; the block does not enforce it.
`default_nettype none

`include "assert_macros.svh"

module timer_rate_calibrator #(
    parameter int TIMER_WIDTH = trc_pkg::TIMER_WIDTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [trc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [trc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire trc_pkg::in_word_t                 in_word,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output trc_pkg::out_word_t                     out_word
);

    localparam int TW  = TIMER_WIDTH;
    localparam int QW  = $bits(trc_pkg::job_ctl_t) + 2 * TW;

    trc_pkg::cfg_t     cfg_reg, cfg_next;
    logic              q_push, q_pop, q_full, q_empty;
    trc_pkg::job_ctl_t push_ctl, head_ctl;
    logic [TW-1:0]     push_dhi, push_dlo, head_dhi, head_dlo;
    logic [QW-1:0]     head_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                trc_pkg::REG_WINDOW_TICKS: cfg_next.window_ticks = cfg_data[trc_pkg::WIN_W-1:0];
                trc_pkg::REG_ROUND_LIMIT:  cfg_next.round_limit  = cfg_data[trc_pkg::CNT_W-1:0];
                trc_pkg::REG_PRESET_RATE:  cfg_next.preset_rate  = cfg_data[trc_pkg::RATE_W-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{window_ticks: trc_pkg::WIN_W'(1),
                         round_limit: trc_pkg::CNT_W'(5),
                         preset_rate: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    trc_front #(.TIMER_WIDTH(TW)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_ctl    (push_ctl),
        .q_dhi    (push_dhi),
        .q_dlo    (push_dlo)
    );

    trc_queue #(.WIDTH(QW), .DEPTH(trc_pkg::QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_ctl, push_dhi, push_dlo}),
        .pop       (q_pop),
        .head_data (head_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign head_ctl = trc_pkg::job_ctl_t'(head_data[QW-1 -: $bits(trc_pkg::job_ctl_t)]);
    assign head_dhi = head_data[2*TW-1:TW];
    assign head_dlo = head_data[TW-1:0];

    trc_back #(.TIMER_WIDTH(TW)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_ctl     (head_ctl),
        .q_dhi     (head_dhi),
        .q_dlo     (head_dlo),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    `ASSERT_SAME(a_no_overflow, q_push, !q_full, "job pushed into a full queue")
    `ASSERT_SAME(a_fail_word, out_valid && out_word.source == trc_pkg::SRC_FAILED,
                 out_word.rate == '0 && out_word.good_rounds == '0, "bad failure word")
    `ASSERT_SAME(a_measured_cnt, out_valid && out_word.source == trc_pkg::SRC_MEASURED,
                 out_word.good_rounds != '0, "measured word without good rounds")
    `ASSERT_SAME(a_pop_nonempty, q_pop, !q_empty, "job popped from an empty queue")
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word),
                 "result word dropped or changed while waiting")

endmodule

`default_nettype wire

// ===== hw/rtl/trc_queue.sv =====
// ----------------------------------------------------------------------------
// Job queue
// Small flop-based FIFO between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = trc_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      head_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_data = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/trc_front.sv =====
// ----------------------------------------------------------------------------
// Calibrator front
// Accepts words, tracks window edges per round and queues evaluation and preset jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_front #(
    parameter int TIMER_WIDTH = trc_pkg::TIMER_WIDTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire trc_pkg::cfg_t          cfg,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire trc_pkg::in_word_t      in_word,
    input  wire logic                   q_full,
    output logic                        q_push,
    output trc_pkg::job_ctl_t           q_ctl,
    output logic [TIMER_WIDTH-1:0]      q_dhi,
    output logic [TIMER_WIDTH-1:0]      q_dlo
);

    localparam int TW = TIMER_WIDTH;

    trc_pkg::phase_t               phase_reg, phase_next;
    logic [trc_pkg::TICK_W-1:0]    base_reg, base_next;
    logic [TW-1:0]                 bs_reg, bs_next;
    logic [TW-1:0]                 as_reg, as_next;
    logic [TW-1:0]                 aft_reg, aft_next;
    logic [TW-1:0]                 be_reg, be_next;
    logic [TW-1:0]                 ae_reg, ae_next;
    logic                          bs_ok_reg, bs_ok_next;
    logic                          be_ok_reg, be_ok_next;
    logic [trc_pkg::CNT_W-1:0]     rounds_reg, rounds_next;
    logic                          first_reg, first_next;

    logic                          accept;
    logic [TW-1:0]                 tv;
    logic [trc_pkg::TICK_W-1:0]    tick;
    logic [trc_pkg::TICK_W-1:0]    lim_start, lim_end, d_start, d_end;
    logic                          np_start, np_end;
    logic [trc_pkg::CNT_W-1:0]     eff_rounds, rounds_inc;
    logic                          last_round;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign tv       = TW'(in_word.timer_count);
    assign tick     = in_word.ref_tick;

    assign lim_start = base_reg + trc_pkg::TICK_W'(1);
    assign lim_end   = lim_start
                     + trc_pkg::TICK_W'(trc_pkg::eff_window(cfg.window_ticks));
    assign d_start   = tick - lim_start;
    assign d_end     = tick - lim_end;
    assign np_start  = (d_start == '0) || d_start[trc_pkg::TICK_W-1];
    assign np_end    = (d_end == '0) || d_end[trc_pkg::TICK_W-1];

    assign eff_rounds = (cfg.round_limit == '0) ? trc_pkg::CNT_W'(1) :
                        (cfg.round_limit > trc_pkg::CNT_W'(trc_pkg::MAX_ROUNDS)) ?
                        trc_pkg::CNT_W'(trc_pkg::MAX_ROUNDS) : cfg.round_limit;
    assign rounds_inc = rounds_reg + 1'b1;
    assign last_round = !(rounds_inc < eff_rounds);

    always_comb
    begin
        phase_next  = phase_reg;
        base_next   = base_reg;
        bs_next     = bs_reg;
        as_next     = as_reg;
        aft_next    = aft_reg;
        be_next     = be_reg;
        ae_next     = ae_reg;
        bs_ok_next  = bs_ok_reg;
        be_ok_next  = be_ok_reg;
        rounds_next = rounds_reg;
        first_next  = first_reg;
        q_push      = 1'b0;
        q_ctl       = '{op: trc_pkg::OP_EVAL, first: first_reg, last: last_round,
                        edges_ok: bs_ok_reg && be_ok_reg};
        q_dhi       = tv - bs_reg;
        q_dlo       = be_reg - aft_reg;

        if (accept)
        begin
            if (in_word.kind == trc_pkg::KIND_START)
            begin
                if (cfg.preset_rate != '0)
                begin
                    phase_next = trc_pkg::PH_IDLE;
                    q_push     = 1'b1;
                    q_ctl.op   = trc_pkg::OP_PRESET;
                end
                else
                begin
                    rounds_next = '0;
                    first_next  = 1'b1;
                    phase_next  = trc_pkg::PH_FIRST;
                end
            end
            else
            begin
                unique case (phase_reg)
                    trc_pkg::PH_FIRST:
                    begin
                        as_next    = tv;
                        base_next  = tick;
                        bs_ok_next = 1'b0;
                        phase_next = trc_pkg::PH_START_EDGE;
                    end
                    trc_pkg::PH_START_EDGE:
                    begin
                        if (np_start)
                        begin
                            bs_next    = as_reg;
                            bs_ok_next = 1'b1;
                            as_next    = tv;
                        end
                        else
                        begin
                            aft_next   = tv;
                            ae_next    = tv;
                            be_ok_next = 1'b0;
                            phase_next = trc_pkg::PH_END_EDGE;
                        end
                    end
                    trc_pkg::PH_END_EDGE:
                    begin
                        if (np_end)
                        begin
                            be_next    = ae_reg;
                            be_ok_next = 1'b1;
                            ae_next    = tv;
                        end
                        else
                        begin
                            q_push      = 1'b1;
                            first_next  = 1'b0;
                            rounds_next = rounds_inc;
                            phase_next  = last_round ? trc_pkg::PH_IDLE : trc_pkg::PH_FIRST;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= trc_pkg::PH_IDLE;
            bs_ok_reg  <= 1'b0;
            be_ok_reg  <= 1'b0;
            rounds_reg <= '0;
            first_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            bs_ok_reg  <= bs_ok_next;
            be_ok_reg  <= be_ok_next;
            rounds_reg <= rounds_next;
            first_reg  <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        bs_reg   <= bs_next;
        as_reg   <= as_next;
        aft_reg  <= aft_next;
        be_reg   <= be_next;
        ae_reg   <= ae_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/trc_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, by a narrow divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_div #(
    parameter int WIDTH = trc_pkg::SUM_W
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [WIDTH-1:0]          dividend,
    input  wire logic [trc_pkg::WIN_W-1:0] divisor,
    output logic                           done,
    output logic [WIDTH-1:0]               quotient
);

    localparam int DV = trc_pkg::WIN_W;
    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] quot_reg, quot_next;
    logic [DV-1:0]    rem_reg, rem_next;
    logic [DV-1:0]    dvs_reg, dvs_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DV:0]      rem_sh, rem_sub;
    logic             ge;

    assign done     = done_reg;
    assign quotient = quot_reg;
    assign rem_sh   = {rem_reg, quot_reg[WIDTH-1]};
    assign rem_sub  = rem_sh - {1'b0, dvs_reg};
    assign ge       = (rem_sh >= {1'b0, dvs_reg});

    always_comb
    begin
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start && !busy_reg)
        begin
            quot_next  = dividend;
            rem_next   = '0;
            dvs_next   = divisor;
            count_next = CW'(WIDTH);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next  = {quot_reg[WIDTH-2:0], ge};
            rem_next   = ge ? rem_sub[DV-1:0] : rem_sh[DV-1:0];
            count_next = count_reg - 1'b1;
            if (count_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/trc_back.sv =====
// ----------------------------------------------------------------------------
// Calibrator back
// Runs queued jobs: rate divisions, round grading, averaging and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_back #(
    parameter int TIMER_WIDTH = trc_pkg::TIMER_WIDTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire trc_pkg::cfg_t          cfg,
    input  wire logic                   q_empty,
    input  wire trc_pkg::job_ctl_t      q_ctl,
    input  wire logic [TIMER_WIDTH-1:0] q_dhi,
    input  wire logic [TIMER_WIDTH-1:0] q_dlo,
    output logic                        q_pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output trc_pkg::out_word_t          out_word
);

    localparam int TW = TIMER_WIDTH;
    localparam int DW = (TW > trc_pkg::SUM_W) ? TW : trc_pkg::SUM_W;
    localparam int RW = trc_pkg::RATE_W;

    trc_pkg::bk_state_t        state_reg, state_next;
    trc_pkg::job_ctl_t         ctl_reg, ctl_next;
    logic [TW-1:0]             dlo_reg, dlo_next;
    logic [TW-1:0]             hi_reg, hi_next;
    logic [trc_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [trc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;
    trc_pkg::out_word_t        out_word_reg, out_word_next;

    logic                      div_start, div_done;
    logic [DW-1:0]             div_dividend, div_quot;
    logic [trc_pkg::WIN_W-1:0] div_divisor, win;
    logic [TW-1:0]             lo, spread;
    logic [DW-1:0]             hi_wide;
    logic [RW-1:0]             hi_sat, mean_sat;
    logic                      good;
    logic [trc_pkg::SUM_W-1:0] sum_upd;
    logic [trc_pkg::CNT_W-1:0] cnt_upd;

    trc_div #(.WIDTH(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign win       = trc_pkg::eff_window(cfg.window_ticks);

    assign lo       = TW'(div_quot);
    assign spread   = hi_reg - lo;
    assign good     = ctl_reg.edges_ok && (spread < (hi_reg >> 3));
    assign hi_wide  = DW'(hi_reg);
    assign hi_sat   = (|hi_wide[DW-1:RW]) ? '1 : hi_wide[RW-1:0];
    assign sum_upd  = good ? sum_reg + trc_pkg::SUM_W'(hi_sat) : sum_reg;
    assign cnt_upd  = good ? cnt_reg + 1'b1 : cnt_reg;
    assign mean_sat = (|div_quot[DW-1:RW]) ? '1 : div_quot[RW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        ctl_next       = ctl_reg;
        dlo_next       = dlo_reg;
        hi_next        = hi_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        div_dividend   = DW'(q_dhi);
        div_divisor    = win;

        unique case (state_reg)
            trc_pkg::BK_IDLE:
            begin
                if (!q_empty && !out_valid_reg)
                begin
                    q_pop = 1'b1;
                    if (q_ctl.op == trc_pkg::OP_PRESET)
                    begin
                        out_valid_next = 1'b1;
                        out_word_next  = '{rate: cfg.preset_rate,
                                          source: trc_pkg::SRC_PRESET,
                                          good_rounds: '0};
                    end
                    else
                    begin
                        ctl_next  = q_ctl;
                        dlo_next  = q_dlo;
                        if (q_ctl.first)
                        begin
                            sum_next = '0;
                            cnt_next = '0;
                        end
                        div_start  = 1'b1;
                        state_next = trc_pkg::BK_HI;
                    end
                end
            end
            trc_pkg::BK_HI:
            begin
                if (div_done)
                begin
                    hi_next      = TW'(div_quot);
                    div_start    = 1'b1;
                    div_dividend = DW'(dlo_reg);
                    state_next   = trc_pkg::BK_LO;
                end
            end
            trc_pkg::BK_LO:
            begin
                if (div_done)
                begin
                    sum_next   = sum_upd;
                    cnt_next   = cnt_upd;
                    state_next = trc_pkg::BK_IDLE;
                    if (ctl_reg.last)
                    begin
                        if (cnt_upd == '0)
                        begin
                            out_valid_next = 1'b1;
                            out_word_next  = '{rate: '0,
                                              source: trc_pkg::SRC_FAILED,
                                              good_rounds: '0};
                        end
                        else
                        begin
                            div_start    = 1'b1;
                            div_dividend = DW'(sum_upd);
                            div_divisor  = trc_pkg::WIN_W'(cnt_upd);
                            state_next   = trc_pkg::BK_MEAN;
                        end
                    end
                end
            end
            trc_pkg::BK_MEAN:
            begin
                if (div_done)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = '{rate: mean_sat,
                                      source: trc_pkg::SRC_MEASURED,
                                      good_rounds: cnt_reg};
                    state_next     = trc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = trc_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= trc_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg      <= ctl_next;
        dlo_reg      <= dlo_next;
        hi_reg       <= hi_next;
        sum_reg      <= sum_next;
        cnt_reg      <= cnt_next;
        out_word_reg <= out_word_next;
    end

endmodule

`default_nettype wire

// ===== tb/sv/timer_rate_calibrator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer rate calibrator testbench
// Feeds start and sample words under a series of register settings, with
// random gaps on both sides. A local model predicts every preset, measured
// and failed result, and each result word is checked field by field.
// ----------------------------------------------------------------------------
module timer_rate_calibrator_tb;
    import trc_pkg::*;

    localparam int HOLD_LIMIT    = 20000;
    localparam int SETTLE_CYCLES = 400;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_word_t              in_word   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_word_t             out_word;

    timer_rate_calibrator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always #5 clk = ~clk;

    // register copy
    logic [WIN_W-1:0]  cur_window = 8'd1;
    logic [CNT_W-1:0]  cur_rounds = 4'd5;
    logic [RATE_W-1:0] cur_preset = '0;

    // calibration state
    phase_t            cal_phase      = PH_IDLE;
    logic [TICK_W-1:0] win_base       = '0;
    logic [RATE_W-1:0] t_before_start = '0;
    logic [RATE_W-1:0] t_at_start     = '0;
    logic [RATE_W-1:0] t_after_start  = '0;
    logic [RATE_W-1:0] t_before_end   = '0;
    logic [RATE_W-1:0] t_at_end       = '0;
    bit                start_edge_ok  = 1'b0;
    bit                end_edge_ok    = 1'b0;
    logic [CNT_W-1:0]  rounds_run     = '0;
    logic [CNT_W-1:0]  good_cnt       = '0;
    logic [SUM_W-1:0]  good_total     = '0;

    out_word_t expected_rates[$];
    in_word_t  pending_words[$];
    out_word_t want;

    int  words_seen    = 0;
    int  measured_seen = 0;
    int  preset_seen   = 0;
    int  failed_seen   = 0;
    int  mismatches    = 0;
    int  words_made    = 0;
    int  settings_done = 0;
    int  send_gap      = 0;
    int  stall_left    = 0;
    int  quiet_cycles  = 0;
    bit  no_idle       = 1'b0;

    function automatic bit tick_not_past(input logic [TICK_W-1:0] tick,
                                         input logic [TICK_W-1:0] lim);
        logic [TICK_W-1:0] d;
        d = tick - lim;
        return (d == '0) || d[TICK_W-1];
    endfunction

    task automatic calibrate_word(input in_word_t w);
        logic [RATE_W-1:0] win;
        logic [CNT_W-1:0]  round_cap;
        logic [RATE_W-1:0] hi;
        logic [RATE_W-1:0] lo;
        logic [RATE_W-1:0] spread;
        logic [SUM_W-1:0]  mean;
        out_word_t         res;
        win       = (cur_window == '0) ? RATE_W'(1) : RATE_W'(cur_window);
        round_cap = (cur_rounds == '0) ? CNT_W'(1) : cur_rounds;
        words_seen++;
        if (w.kind == KIND_START)
        begin
            if (cur_preset != '0)
            begin
                cal_phase       = PH_IDLE;
                res.rate        = cur_preset;
                res.source      = SRC_PRESET;
                res.good_rounds = '0;
                expected_rates.push_back(res);
                preset_seen++;
            end
            else
            begin
                rounds_run = '0;
                good_cnt   = '0;
                good_total = '0;
                cal_phase  = PH_FIRST;
            end
        end
        else
        begin
            case (cal_phase)
                PH_FIRST:
                begin
                    t_at_start    = w.timer_count;
                    win_base      = w.ref_tick;
                    start_edge_ok = 1'b0;
                    cal_phase     = PH_START_EDGE;
                end
                PH_START_EDGE:
                begin
                    if (tick_not_past(w.ref_tick, win_base + 32'd1))
                    begin
                        t_before_start = t_at_start;
                        start_edge_ok  = 1'b1;
                        t_at_start     = w.timer_count;
                    end
                    else
                    begin
                        t_after_start = w.timer_count;
                        t_at_end      = w.timer_count;
                        end_edge_ok   = 1'b0;
                        cal_phase     = PH_END_EDGE;
                    end
                end
                PH_END_EDGE:
                begin
                    if (tick_not_past(w.ref_tick, win_base + 32'd1 + win))
                    begin
                        t_before_end = t_at_end;
                        end_edge_ok  = 1'b1;
                        t_at_end     = w.timer_count;
                    end
                    else
                    begin
                        hi     = (w.timer_count - t_before_start) / win;
                        lo     = (t_before_end - t_after_start) / win;
                        spread = hi - lo;
                        if (start_edge_ok && end_edge_ok && spread < (hi >> 3))
                        begin
                            good_total += SUM_W'(hi);
                            good_cnt++;
                        end
                        rounds_run++;
                        if (rounds_run < round_cap)
                            cal_phase = PH_FIRST;
                        else
                        begin
                            cal_phase = PH_IDLE;
                            if (good_cnt != '0)
                            begin
                                mean     = good_total / SUM_W'(good_cnt);
                                res.rate = (mean > SUM_W'(32'hFFFF_FFFF)) ? '1
                                                                          : mean[RATE_W-1:0];
                                res.source      = SRC_MEASURED;
                                res.good_rounds = good_cnt;
                                measured_seen++;
                            end
                            else
                            begin
                                res.rate        = '0;
                                res.source      = SRC_FAILED;
                                res.good_rounds = '0;
                                failed_seen++;
                            end
                            expected_rates.push_back(res);
                        end
                    end
                end
                default: ;
            endcase
        end
    endtask

    // input side: hold each word until taken, then maybe pause
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                calibrate_word(in_word);
                if (!no_idle && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 5);
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    in_word  <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result side: check each word against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_rates.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result rate %h source %0d good %0d", $time,
                             out_word.rate, out_word.source, out_word.good_rounds);
                end
                else
                begin
                    want = expected_rates.pop_front();
                    if (out_word.rate !== want.rate || out_word.source !== want.source ||
                        out_word.good_rounds !== want.good_rounds)
                    begin
                        mismatches++;
                        $display("%0t: expected %h/%0d/%0d, got %h/%0d/%0d (rate/source/good)",
                                 $time, want.rate, want.source, want.good_rounds,
                                 out_word.rate, out_word.source, out_word.good_rounds);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= HOLD_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, HOLD_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_WINDOW_TICKS: cur_window = data[WIN_W-1:0];
            REG_ROUND_LIMIT:  cur_rounds = data[CNT_W-1:0];
            REG_PRESET_RATE:  cur_preset = data;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_registers(input logic [WIN_W-1:0] win, input logic [CNT_W-1:0] rounds,
                                 input logic [RATE_W-1:0] preset);
        write_reg(REG_WINDOW_TICKS, {24'($urandom), win});
        write_reg(REG_ROUND_LIMIT, {28'($urandom), rounds});
        write_reg(REG_PRESET_RATE, preset);
        settings_done++;
        @(negedge clk);
    endtask

    task automatic queue_word(input logic kind, input logic [RATE_W-1:0] tv,
                              input logic [TICK_W-1:0] tick, input bit counted);
        in_word_t w;
        w.kind        = kind;
        w.timer_count = tv;
        w.ref_tick    = tick;
        pending_words.push_back(w);
        if (counted)
            words_made++;
    endtask

    function automatic logic [RATE_W-1:0] timer_at(input logic [RATE_W-1:0] t0, input int d,
                                                   input logic [RATE_W-1:0] rate,
                                                   input bit scramble);
        if (scramble)
            return $urandom;
        return t0 + d * rate + $urandom_range(0, rate >> 6);
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate(input int unsigned win);
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, 100);
            1:       return $urandom_range(100, 100000);
            2:       return $urandom_range(100000, 1 << 24);
            default: return $urandom_range(1, 32'hFFFF_FFFF / (win + 3));
        endcase
    endfunction

    function automatic int edge_samples();
        return ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
    endfunction

    // one round: start-edge samples, window samples, closing sample; cut truncates
    task automatic queue_round(input int win, input logic [RATE_W-1:0] rate, input int n_before,
                               input int n_inside, input bit scramble, input int cut);
        logic [TICK_W-1:0] base;
        logic [RATE_W-1:0] t0;
        int                offs[$];
        int                d;
        base = $urandom;
        t0   = $urandom;
        offs.push_back(0);
        for (int i = 0; i < n_before; i++)
            offs.push_back((2 * i >= n_before) ? 1 : 0);
        offs.push_back(2);
        for (int i = 0; i < n_inside; i++)
        begin
            d = 1 + win - (n_inside - 1 - i);
            offs.push_back((d < 2) ? 2 : d);
        end
        offs.push_back(2 + win + $urandom_range(0, 1));
        foreach (offs[i])
            if (i < cut)
                queue_word(KIND_SAMPLE, timer_at(t0, offs[i], rate, scramble),
                           base + offs[i], 1'b1);
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_rates.size() != 0);
    endtask

    // finish any open calibration, then let the back end go quiet
    task automatic settle();
        logic [TICK_W-1:0] tick;
        drain();
        while (cal_phase != PH_IDLE)
        begin
            tick = win_base + TICK_W'(300);
            queue_word(KIND_SAMPLE, $urandom, tick, 1'b0);
            drain();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [WIN_W-1:0]  win_set;
        logic [CNT_W-1:0]  rounds_set;
        logic [RATE_W-1:0] preset_set;
        int                eff_win;
        int                eff_rnds;
        int                n_cal;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // zero window, zero round limit, samples while idle, restart, missing edges
        set_registers(8'd0, 4'd0, '0);
        queue_word(KIND_SAMPLE, '1, '1, 1'b0);
        queue_word(KIND_SAMPLE, '0, '0, 1'b0);
        queue_word(KIND_START, '1, '0, 1'b1);
        queue_word(KIND_START, '0, '1, 1'b1);
        queue_word(KIND_SAMPLE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        queue_word(KIND_SAMPLE, 32'h0000_0100, 32'h0000_0001, 1'b1);
        queue_word(KIND_SAMPLE, 32'h0000_0200, 32'h0000_0002, 1'b1);
        queue_word(KIND_SAMPLE, '1, 32'h0000_0003, 1'b0);
        settle();

        // widest window: a clean round at the top rate, then a round across the tick sign boundary that fails
        set_registers(8'd255, 4'd1, '0);
        queue_word(KIND_START, $urandom, $urandom, 1'b1);
        queue_round(255, 32'hFFFF_FFFF / 260, 1, 1, 1'b0, 100);
        queue_word(KIND_START, $urandom, $urandom, 1'b1);
        queue_word(KIND_SAMPLE, 32'd1000, 32'h7FFF_FFF0, 1'b1);
        queue_word(KIND_SAMPLE, 32'd2000, 32'h7FFF_FFF1, 1'b1);
        queue_word(KIND_SAMPLE, 32'd3000, 32'h7FFF_FFF2, 1'b1);
        queue_word(KIND_SAMPLE, 32'h8000_0000, 32'h8000_00F0, 1'b1);
        queue_word(KIND_SAMPLE, 32'd4000, 32'h8000_00F1, 1'b1);
        settle();

        // preset answers at once
        set_registers(8'd1, 4'd15, '1);
        queue_word(KIND_START, '0, '0, 1'b1);
        queue_word(KIND_SAMPLE, $urandom, $urandom, 1'b0);
        queue_word(KIND_START, '1, '1, 1'b1);
        settle();

        while (words_made < 400)
        begin
            if (words_made >= 320)
                no_idle = 1'b1;
            case ($urandom_range(0, 5))
                0:       win_set = 8'd0;
                1:       win_set = 8'd1;
                2:       win_set = 8'd255;
                default: win_set = 8'($urandom_range(20, 255));
            endcase
            case ($urandom_range(0, 7))
                0:       rounds_set = 4'd0;
                1:       rounds_set = 4'd15;
                default: rounds_set = 4'($urandom_range(1, 3));
            endcase
            case ($urandom_range(0, 5))
                0:       preset_set = $urandom;
                1:       preset_set = '1;
                default: preset_set = '0;
            endcase
            set_registers(win_set, rounds_set, preset_set);
            eff_win  = (win_set == '0) ? 1 : int'(win_set);
            eff_rnds = (rounds_set == '0) ? 1 : int'(rounds_set);
            if (preset_set != '0)
            begin
                repeat ($urandom_range(3, 6))
                begin
                    queue_word(KIND_START, $urandom, $urandom, 1'b1);
                    if ($urandom_range(0, 1) == 1)
                        queue_word(KIND_SAMPLE, $urandom, $urandom, 1'b0);
                end
            end
            else
            begin
                n_cal = (eff_rnds > 3) ? 1 : $urandom_range(2, 4);
                repeat (n_cal)
                begin
                    case ($urandom_range(0, 9))
                        0:
                            repeat (3) queue_word(1'($urandom), $urandom, $urandom, 1'b0);
                        1:
                        begin
                            queue_word(KIND_START, $urandom, $urandom, 1'b1);
                            queue_round(eff_win, pick_rate(eff_win), edge_samples(),
                                        edge_samples(), 1'b0, $urandom_range(1, 4));
                        end
                        default:
                        begin
                            queue_word(KIND_START, $urandom, $urandom, 1'b1);
                            repeat (eff_rnds)
                                queue_round(eff_win, pick_rate(eff_win), edge_samples(),
                                            edge_samples(), $urandom_range(0, 7) == 0, 100);
                        end
                    endcase
                end
            end
            settle();
        end

        $display("Sent %0d words under %0d register settings.", words_seen, settings_done);
        $display("Checked %0d measured, %0d preset and %0d failed calibration results.",
                 measured_seen, preset_seen, failed_seen);
        if (mismatches == 0 && expected_rates.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
